>>> src/pfde_pkg.sv
// Package: shared constants, command types and font table for the draw engine.
`timescale 1ns / 1ps
package pfde_pkg;
	localparam int SCREEN_WIDTH = 128;
	localparam int SCREEN_HEIGHT = 64;
	localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
	localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
	localparam int ADDR_W = $clog2(STORE_BYTES);
	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] FUNC_CLEAR = 3'd0;
	localparam logic [2:0] FUNC_PIXEL = 3'd1;
	localparam logic [2:0] FUNC_RECT  = 3'd2;
	localparam logic [2:0] FUNC_CHAR  = 3'd3;
	localparam logic [2:0] FUNC_READ  = 3'd4;

	// classified command handed from the front to the back
	typedef struct packed {
		logic [2:0] func;
		logic signed [8:0] pos_x;
		logic signed [8:0] pos_y;
		logic [7:0] rect_width;
		logic [7:0] rect_height;
		logic [34:0] glyph;      // column i occupies bits [7*i +: 7]
		logic color;
		logic [9:0] read_index;
	} cmd_t;

	function automatic logic [34:0] glyph_lookup(input logic [7:0] code_in);
		logic [7:0] c;
		logic [34:0] g;
		begin
			c = code_in;
			if (c >= 8'h61 && c <= 8'h7A) c = c - 8'd32;
			g = '0;
			case (c)
			8'h30: g = {7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E};
			8'h31: g = {7'h00, 7'h40, 7'h7F, 7'h42, 7'h00};
			8'h32: g = {7'h46, 7'h49, 7'h51, 7'h61, 7'h42};
			8'h33: g = {7'h31, 7'h4B, 7'h45, 7'h41, 7'h21};
			8'h34: g = {7'h10, 7'h7F, 7'h12, 7'h14, 7'h18};
			8'h35: g = {7'h39, 7'h45, 7'h45, 7'h45, 7'h27};
			8'h36: g = {7'h30, 7'h49, 7'h49, 7'h4A, 7'h3C};
			8'h37: g = {7'h03, 7'h05, 7'h09, 7'h71, 7'h01};
			8'h38: g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
			8'h39: g = {7'h1E, 7'h29, 7'h49, 7'h49, 7'h06};
			8'h41: g = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
			8'h42: g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h7F};
			8'h43: g = {7'h22, 7'h41, 7'h41, 7'h41, 7'h3E};
			8'h44: g = {7'h1C, 7'h22, 7'h41, 7'h41, 7'h7F};
			8'h45: g = {7'h41, 7'h49, 7'h49, 7'h49, 7'h7F};
			8'h46: g = {7'h01, 7'h09, 7'h09, 7'h09, 7'h7F};
			8'h47: g = {7'h7A, 7'h49, 7'h49, 7'h41, 7'h3E};
			8'h48: g = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
			8'h49: g = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
			8'h4A: g = {7'h01, 7'h3F, 7'h41, 7'h40, 7'h20};
			8'h4B: g = {7'h41, 7'h22, 7'h14, 7'h08, 7'h7F};
			8'h4C: g = {7'h40, 7'h40, 7'h40, 7'h40, 7'h7F};
			8'h4D: g = {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F};
			8'h4E: g = {7'h7F, 7'h10, 7'h08, 7'h04, 7'h7F};
			8'h4F: g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
			8'h50: g = {7'h06, 7'h09, 7'h09, 7'h09, 7'h7F};
			8'h51: g = {7'h5E, 7'h21, 7'h51, 7'h41, 7'h3E};
			8'h52: g = {7'h46, 7'h29, 7'h19, 7'h09, 7'h7F};
			8'h53: g = {7'h31, 7'h49, 7'h49, 7'h49, 7'h46};
			8'h54: g = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
			8'h55: g = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
			8'h56: g = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
			8'h57: g = {7'h7F, 7'h20, 7'h18, 7'h20, 7'h7F};
			8'h58: g = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
			8'h59: g = {7'h03, 7'h04, 7'h78, 7'h04, 7'h03};
			8'h5A: g = {7'h43, 7'h45, 7'h49, 7'h51, 7'h61};
			8'h3A: g = {7'h00, 7'h00, 7'h36, 7'h36, 7'h00};
			8'h2B: g = {7'h08, 7'h08, 7'h3E, 7'h08, 7'h08};
			8'h2D: g = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
			8'h21: g = {7'h00, 7'h00, 7'h5F, 7'h00, 7'h00};
			default: g = '0;
			endcase
			return g;
		end
	endfunction
endpackage

>>> src/pfde_front.sv
// Front end: accepts commands, looks up the glyph and queues them for the back end.
`timescale 1ns / 1ps
module pfde_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  pfde_pkg::cmd_t in_cmd,
	output logic q_valid,
	input  logic q_ready,
	output pfde_pkg::cmd_t q_cmd
);
	import pfde_pkg::*;

	cmd_t mem_q [QUEUE_DEPTH];
	logic wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic push, pop;
	cmd_t cls;

	always_comb begin
		cls = in_cmd;
		cls.glyph = glyph_lookup(in_cmd.glyph[7:0]);
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = mem_q[rptr_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

>>> src/pfde_back.sv
// Back end: walks pixels or bytes of one command over the frame store.
`timescale 1ns / 1ps
module pfde_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_ready,
	input  pfde_pkg::cmd_t q_cmd,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] out_data
);
	import pfde_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CLR  = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;   // read byte of a pixel
	localparam logic [2:0] ST_WR   = 3'd3;   // modify and write it back
	localparam logic [2:0] ST_RDO  = 3'd4;   // read command, data on next cycle
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0] state_q;
	cmd_t cmd_q;
	logic [7:0] i_q, j_q;
	logic [ADDR_W-1:0] clr_q;
	logic init_q;   // clearing pass after reset, no transfer at its end
	logic [7:0] mem [STORE_BYTES];
	logic [7:0] rd_q;
	logic rd_zero_q;
	logic [ADDR_W-1:0] addr_q;
	logic [2:0] bit_q;
	logic [7:0] res_q;
	logic outv_q;

	logic signed [9:0] px, py;
	logic on_screen, bit_on, last;
	logic [7:0] i_lim, j_lim;
	logic [ADDR_W-1:0] paddr;
	logic [6:0] gcol;

	always_comb begin
		px = {cmd_q.pos_x[8], cmd_q.pos_x} + $signed({2'b0, i_q});
		py = {cmd_q.pos_y[8], cmd_q.pos_y} + $signed({2'b0, j_q});
		on_screen = (px >= 0) && (px < SCREEN_WIDTH) && (py >= 0) && (py < SCREEN_HEIGHT);
		paddr = ADDR_W'(px[8:0]) + ADDR_W'(py[8:3]) * ADDR_W'(SCREEN_WIDTH);
		gcol = cmd_q.glyph[7*i_q[2:0] +: 7];
		unique case (cmd_q.func)
		FUNC_RECT: begin
			i_lim = cmd_q.rect_width; j_lim = cmd_q.rect_height;
			bit_on = 1'b1;
		end
		FUNC_CHAR: begin
			i_lim = 8'd5; j_lim = 8'd7;
			bit_on = gcol[j_q[2:0]];
		end
		default: begin
			i_lim = 8'd1; j_lim = 8'd1;
			bit_on = 1'b1;
		end
		endcase
		last = (i_q == i_lim - 8'd1) && (j_q == j_lim - 8'd1);
	end

	assign q_ready = (state_q == ST_IDLE) && !outv_q;
	assign out_valid = outv_q;
	assign out_data = res_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_CLR) mem[clr_q] <= 8'd0;
		else if (state_q == ST_WR)
			mem[addr_q] <= cmd_q.color ? (rd_q | (8'd1 << bit_q)) : (rd_q & ~(8'd1 << bit_q));
		rd_q <= mem[(state_q == ST_RD) ? paddr : cmd_q.read_index[ADDR_W-1:0]];
		if (state_q == ST_RD) begin
			addr_q <= paddr;
			bit_q <= py[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			init_q <= 1'b1;
			cmd_q <= '0;
			i_q <= '0; j_q <= '0; clr_q <= '0;
			outv_q <= 1'b0; res_q <= '0; rd_zero_q <= 1'b0;
		end else begin
			if (outv_q && out_ready) outv_q <= 1'b0;
			unique case (state_q)
			ST_IDLE: if (q_valid && q_ready) begin
				cmd_q <= q_cmd;
				i_q <= '0; j_q <= '0; clr_q <= '0;
				res_q <= '0;
				unique case (q_cmd.func)
				FUNC_CLEAR: state_q <= ST_CLR;
				FUNC_PIXEL, FUNC_CHAR: state_q <= ST_RD;
				FUNC_RECT: state_q <= (q_cmd.rect_width == 8'd0 || q_cmd.rect_height == 8'd0)
					? ST_OUT : ST_RD;
				FUNC_READ: begin
					state_q <= ST_RDO;
					rd_zero_q <= ({1'b0, q_cmd.read_index} >= 11'(STORE_BYTES));
				end
				default: state_q <= ST_OUT;
				endcase
			end
			ST_CLR: begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == ADDR_W'(STORE_BYTES - 1)) begin
					state_q <= init_q ? ST_IDLE : ST_OUT;
					init_q <= 1'b0;
				end
			end
			ST_RD: begin
				if (on_screen && bit_on) state_q <= ST_WR;
				else if (last) state_q <= ST_OUT;
				// a written last pixel parks i_q at the limit so ST_WR ends the walk
				if (on_screen && bit_on && last) i_q <= i_lim;
				else if (j_q == j_lim - 8'd1) begin
					j_q <= '0; i_q <= i_q + 8'd1;
				end else j_q <= j_q + 8'd1;
			end
			ST_WR: begin
				if (i_q == i_lim) state_q <= ST_OUT;
				else state_q <= ST_RD;
			end
			ST_RDO: begin
				state_q <= ST_OUT;
			end
			ST_OUT: begin
				outv_q <= 1'b1;
				if (cmd_q.func == FUNC_READ && !rd_zero_q) res_q <= rd_q;
				state_q <= ST_IDLE;
			end
			default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> src/page_framebuffer_draw_engine.sv
// Top level of the paged 1-bit frame buffer draw engine.
`timescale 1ns / 1ps
// Draw engine for a 128x64 monochrome frame buffer stored as 8 pages of 128
// bytes (pixel x,y is byte x + (y/8)*128, bit y%8). Each command on the slave
// stream gives exactly one transfer on the master stream: the addressed byte
// for a read, zero otherwise. A front end classifies commands and looks up the
// glyph, and a two-entry queue lets it take a new command while the back end
// works. The back end owns the frame store RAM: clear all zeroes every byte in
// turn; a pixel, rectangle or character visits each of its pixels in ST_RD and
// spends one more ST_WR step per pixel actually written (read-modify-write of
// the RAM byte); a read goes through ST_RDO and then ST_OUT. After reset the
// back end runs the same clearing pass before it takes the first command, so
// the store starts blank; commands wait in the queue meanwhile.
module page_framebuffer_draw_engine (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// tdata: func[2:0], pos_x[11:3], pos_y[20:12], rect_width[28:21],
	// rect_height[36:29], char_code[44:37], color[45], read_index[55:46]
	input  logic [55:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// tdata: read_data[7:0]
	output logic [7:0] m_axis_tdata
);
	import pfde_pkg::*;

	cmd_t in_cmd, q_cmd;
	logic q_valid, q_ready;

	always_comb begin
		in_cmd = '0;
		in_cmd.func = s_axis_tdata[2:0];
		in_cmd.pos_x = s_axis_tdata[11:3];
		in_cmd.pos_y = s_axis_tdata[20:12];
		in_cmd.rect_width = s_axis_tdata[28:21];
		in_cmd.rect_height = s_axis_tdata[36:29];
		in_cmd.glyph = {27'd0, s_axis_tdata[44:37]};   // char code, decoded in front
		in_cmd.color = s_axis_tdata[45];
		in_cmd.read_index = s_axis_tdata[55:46];
	end

	pfde_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd,
		.q_valid, .q_ready, .q_cmd
	);

	pfde_back u_back (
		.clk, .arst_n,
		.q_valid, .q_ready, .q_cmd,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
	);
endmodule

>>> tb/tb.sv
// Testbench for the paged frame buffer draw engine: directed table, then random commands.
`timescale 1ns / 1ps
module tb;
	import pfde_pkg::*;

	localparam logic [2:0] FUNC_SPARE = 3'd5;
	localparam int STALL_MAX = 13;
	localparam int IDLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1630;
	localparam int NO_CHECK = -1;

	typedef struct {
		logic [2:0] func;
		logic signed [8:0] pos_x;
		logic signed [8:0] pos_y;
		logic [7:0] rect_width;
		logic [7:0] rect_height;
		logic [7:0] char_code;
		logic color;
		logic [9:0] read_index;
		int known_byte;  // typed result, or NO_CHECK to use the predictor
	} draw_cmd_t;

	// font columns, bit j of column i is glyph row j
	localparam logic [7:0] DIGIT_COLS [0:49] = '{
		8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E, 8'h00, 8'h42, 8'h7F, 8'h40, 8'h00,
		8'h42, 8'h61, 8'h51, 8'h49, 8'h46, 8'h21, 8'h41, 8'h45, 8'h4B, 8'h31,
		8'h18, 8'h14, 8'h12, 8'h7F, 8'h10, 8'h27, 8'h45, 8'h45, 8'h45, 8'h39,
		8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30, 8'h01, 8'h71, 8'h09, 8'h05, 8'h03,
		8'h36, 8'h49, 8'h49, 8'h49, 8'h36, 8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
	localparam logic [7:0] LETTER_COLS [0:129] = '{
		8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E, 8'h7F, 8'h49, 8'h49, 8'h49, 8'h36,
		8'h3E, 8'h41, 8'h41, 8'h41, 8'h22, 8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C,
		8'h7F, 8'h49, 8'h49, 8'h49, 8'h41, 8'h7F, 8'h09, 8'h09, 8'h09, 8'h01,
		8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A, 8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F,
		8'h00, 8'h41, 8'h7F, 8'h41, 8'h00, 8'h20, 8'h40, 8'h41, 8'h3F, 8'h01,
		8'h7F, 8'h08, 8'h14, 8'h22, 8'h41, 8'h7F, 8'h40, 8'h40, 8'h40, 8'h40,
		8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F, 8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F,
		8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E, 8'h7F, 8'h09, 8'h09, 8'h09, 8'h06,
		8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E, 8'h7F, 8'h09, 8'h19, 8'h29, 8'h46,
		8'h46, 8'h49, 8'h49, 8'h49, 8'h31, 8'h01, 8'h01, 8'h7F, 8'h01, 8'h01,
		8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F, 8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F,
		8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F, 8'h63, 8'h14, 8'h08, 8'h14, 8'h63,
		8'h03, 8'h04, 8'h78, 8'h04, 8'h03, 8'h61, 8'h51, 8'h49, 8'h45, 8'h43};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;

	logic [7:0] shadow_frame [STORE_BYTES];
	logic [7:0] expected_bytes [$];
	draw_cmd_t directed_rows [$];
	int fail_count = 0;
	int idle_cycles = 0;
	bit sender_burst = 0;
	bit receiver_burst = 0;

	page_framebuffer_draw_engine dut (.*);

	always #5 clk = ~clk;

	function automatic logic [7:0] font_column(input logic [7:0] code, input int col);
		logic [7:0] c;
		c = code;
		if (c >= "a" && c <= "z") c = c - 8'd32;
		if (c >= "0" && c <= "9") return DIGIT_COLS[(c - "0") * 5 + col];
		if (c >= "A" && c <= "Z") return LETTER_COLS[(c - "A") * 5 + col];
		case (c)
		":": return (col == 1 || col == 2) ? 8'h36 : 8'h00;
		"+": return (col == 2) ? 8'h3E : 8'h08;
		"-": return 8'h08;
		"!": return (col == 2) ? 8'h5F : 8'h00;
		default: return 8'h00;
		endcase
	endfunction

	function automatic void set_pixel(input int x, input int y, input logic on);
		int idx;
		if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT) return;
		idx = x + (y / 8) * SCREEN_WIDTH;
		shadow_frame[idx][y % 8] = on;
	endfunction

	// applies one command to the shadow frame and returns the byte it reports
	function automatic logic [7:0] apply_draw(input draw_cmd_t c);
		int x;
		int y;
		logic [7:0] col;
		x = c.pos_x;
		y = c.pos_y;
		case (c.func)
		FUNC_CLEAR: foreach (shadow_frame[k]) shadow_frame[k] = '0;
		FUNC_PIXEL: set_pixel(x, y, c.color);
		FUNC_RECT:
			for (int j = 0; j < c.rect_height; j++)
				for (int i = 0; i < c.rect_width; i++)
					set_pixel(x + i, y + j, c.color);
		FUNC_CHAR:
			for (int i = 0; i < 5; i++) begin
				col = font_column(c.char_code, i);
				for (int j = 0; j < 7; j++)
					if (col[j]) set_pixel(x + i, y + j, c.color);
			end
		FUNC_READ:
			if (c.read_index < STORE_BYTES) return shadow_frame[c.read_index];
		default: ;
		endcase
		return 8'h00;
	endfunction

	function automatic draw_cmd_t row(input logic [2:0] f, input int x, input int y,
			input int w, input int h, input int code, input logic on, input int idx,
			input int known);
		draw_cmd_t c;
		c.func = f;
		c.pos_x = x;
		c.pos_y = y;
		c.rect_width = w;
		c.rect_height = h;
		c.char_code = code;
		c.color = on;
		c.read_index = idx;
		c.known_byte = known;
		return c;
	endfunction

	function automatic draw_cmd_t random_cmd();
		draw_cmd_t c;
		int pick;
		pick = $urandom_range(0, 999);
		c = row(FUNC_PIXEL, 0, 0, 0, 0, 0, 0, 0, NO_CHECK);
		c.color = $urandom_range(0, 3) != 0;
		c.char_code = $urandom;
		c.read_index = $urandom;
		if ($urandom_range(0, 9) < 8) begin
			c.pos_x = $urandom_range(0, 141) - 8;
			c.pos_y = $urandom_range(0, 77) - 8;
		end else begin
			c.pos_x = $urandom;
			c.pos_y = $urandom;
		end
		c.rect_width = $urandom_range(0, 16);
		c.rect_height = $urandom_range(0, 16);
		if (pick < 10) c.func = FUNC_CLEAR;
		else if (pick < 260) c.func = FUNC_PIXEL;
		else if (pick < 470) c.func = FUNC_RECT;
		else if (pick < 474) begin
			// rare big rectangle, exercises the top width and height bits
			c.func = FUNC_RECT;
			c.rect_width = $urandom_range(128, 255);
			c.rect_height = $urandom_range(64, 255);
		end else if (pick < 700) begin
			c.func = FUNC_CHAR;
			if ($urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 3))
				0: c.char_code = $urandom_range("0", "9");
				1: c.char_code = $urandom_range("A", "Z");
				2: c.char_code = $urandom_range("a", "z");
				default: c.char_code = $urandom_range(0, 1) ? ":" : "!";
				endcase
			end
		end else if (pick < 970) c.func = FUNC_READ;
		else c.func = $urandom_range(FUNC_SPARE, 7);
		return c;
	endfunction

	// one command: gap, present, wait for the transfer, record the expectation
	task automatic send_cmd(input draw_cmd_t c);
		int gap;
		logic [7:0] want;
		gap = sender_burst ? 0 : $urandom_range(0, STALL_MAX);
		if (gap != 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata = {c.read_index, c.color, c.char_code, c.rect_height,
			c.rect_width, c.pos_y, c.pos_x, c.func};
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		want = apply_draw(c);
		if (c.known_byte != NO_CHECK) want = c.known_byte;
		expected_bytes.push_back(want);
		@(negedge clk);
	endtask

	initial begin
		foreach (shadow_frame[k]) shadow_frame[k] = '0;
		directed_rows.push_back(row(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 8'h00));
		directed_rows.push_back(row(FUNC_READ, 0, 0, 0, 0, 0, 0, 1023, 8'h00));
		directed_rows.push_back(row(FUNC_PIXEL, 0, 0, 0, 0, 0, 1, 0, 8'h00));
		directed_rows.push_back(row(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 8'h01));
		directed_rows.push_back(row(FUNC_PIXEL, 127, 63, 0, 0, 0, 1, 0, 8'h00));
		directed_rows.push_back(row(FUNC_READ, 0, 0, 0, 0, 0, 0, 1023, 8'h80));
		// off-screen pixels are dropped
		directed_rows.push_back(row(FUNC_PIXEL, -1, 0, 0, 0, 0, 1, 0, 8'h00));
		directed_rows.push_back(row(FUNC_PIXEL, 128, 5, 0, 0, 0, 1, 0, 8'h00));
		directed_rows.push_back(row(FUNC_PIXEL, 3, 64, 0, 0, 0, 1, 0, 8'h00));
		directed_rows.push_back(row(FUNC_PIXEL, -256, -256, 0, 0, 0, 1, 0, 8'h00));
		directed_rows.push_back(row(FUNC_PIXEL, 255, 255, 0, 0, 0, 1, 0, 8'h00));
		// empty rectangles, then one that covers the whole screen
		directed_rows.push_back(row(FUNC_RECT, 0, 0, 0, 9, 0, 1, 0, 8'h00));
		directed_rows.push_back(row(FUNC_RECT, 0, 0, 9, 0, 0, 1, 0, 8'h00));
		directed_rows.push_back(row(FUNC_RECT, -64, -32, 255, 255, 0, 1, 0, 8'h00));
		directed_rows.push_back(row(FUNC_READ, 0, 0, 0, 0, 0, 0, 517, 8'hFF));
		directed_rows.push_back(row(FUNC_RECT, 10, 3, 20, 9, 0, 0, 0, 8'h00));
		directed_rows.push_back(row(FUNC_READ, 0, 0, 0, 0, 0, 0, 140, NO_CHECK));
		// clear ignores color
		directed_rows.push_back(row(FUNC_CLEAR, 0, 0, 0, 0, 0, 1, 0, 8'h00));
		directed_rows.push_back(row(FUNC_READ, 0, 0, 0, 0, 0, 0, 517, 8'h00));
		directed_rows.push_back(row(FUNC_CHAR, 0, 0, 0, 0, "a", 1, 0, 8'h00));
		directed_rows.push_back(row(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 8'h7E));
		directed_rows.push_back(row(FUNC_CHAR, 6, 0, 0, 0, "!", 1, 0, 8'h00));
		directed_rows.push_back(row(FUNC_CHAR, 124, 60, 0, 0, "Z", 1, 0, 8'h00));
		directed_rows.push_back(row(FUNC_CHAR, 20, 12, 0, 0, 8'hFF, 1, 0, 8'h00));
		directed_rows.push_back(row(FUNC_CHAR, 20, 12, 0, 0, "8", 1, 0, 8'h00));
		directed_rows.push_back(row(FUNC_READ, 0, 0, 0, 0, 0, 0, 149, NO_CHECK));
		directed_rows.push_back(row(FUNC_SPARE, 0, 0, 0, 0, 0, 1, 8, 8'h00));
		directed_rows.push_back(row(3'd7, 0, 0, 0, 0, 0, 1, 8, 8'h00));

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (directed_rows[r]) send_cmd(directed_rows[r]);
		// hold off until the directed part has fully drained
		s_axis_tvalid = 1'b0;
		wait (expected_bytes.size() == 0);
		@(negedge clk);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) sender_burst = $urandom_range(0, 3) == 0;
			if (n % 50 == 0) receiver_burst = $urandom_range(0, 3) == 0;
			send_cmd(random_cmd());
		end
		s_axis_tvalid = 1'b0;
		wait (expected_bytes.size() == 0);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("** page_framebuffer_draw_engine: PASSED **");
		else
			$display("** page_framebuffer_draw_engine: FAILED **");
		$finish;
	end

	// result side back-pressure, redrawn per result
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = receiver_burst ? 0 : $urandom_range(0, STALL_MAX);
			m_axis_tready = 1'b0;
			repeat (stall) @(negedge clk);
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// check each result transfer against the oldest expectation
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_bytes.size() == 0) begin
				$error("read_data: no result expected, got %02h", m_axis_tdata);
				fail_count++;
			end else begin
				if (m_axis_tdata !== expected_bytes[0]) begin
					$error("read_data: expected %02h, actual %02h",
						expected_bytes[0], m_axis_tdata);
					fail_count++;
				end
				void'(expected_bytes.pop_front());
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("** page_framebuffer_draw_engine: FAILED **");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end
endmodule
